[rtl/core/bate_pkg.sv]
// ----------------------------------------------------------------------------
// bate_pkg: shared types and constants of the bounded table engine
// Action codes, widths, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package bate_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int KEY_W          = 32;
	localparam int INDEX_W        = 7;
	localparam int POS_W          = 6;
	localparam int FILL_W         = 7;
	localparam int ACTION_W       = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND       = 4'd0,
		ACT_PREPEND      = 4'd1,
		ACT_INSERT_AT    = 4'd2,
		ACT_REMOVE_LAST  = 4'd3,
		ACT_REMOVE_FIRST = 4'd4,
		ACT_REMOVE_AT    = 4'd5,
		ACT_FIND         = 4'd6,
		ACT_READ         = 4'd7,
		ACT_SORT         = 4'd8
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHUP_RD,
		ST_SHUP_WR,
		ST_SHDN_RD,
		ST_SHDN_WR,
		ST_FIND_RD,
		ST_FIND_CMP,
		ST_READ_RD,
		ST_READ_WAIT,
		ST_SORT_LD,
		ST_SORT_LDW,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_DONE
	} state_t;

	// Address source for the store port.
	typedef enum logic [1:0] {
		ADR_I,
		ADR_J,
		ADR_JM1,
		ADR_JP1
	} adr_sel_t;

	// Write data source for the store port.
	typedef enum logic [1:0] {
		WD_KEY,
		WD_RDATA,
		WD_HELD
	} wd_sel_t;

	typedef struct packed {
		logic     load;       // capture request and counters
		logic     rd_en;
		adr_sel_t rd_adr;
		logic     wr_en;
		adr_sel_t wr_adr;
		wd_sel_t  wr_dat;
		logic     j_dec;
		logic     j_inc;
		logic     j_from_i;
		logic     i_inc;
		logic     hold_ld;    // sort: latch read data as held value
		logic     cnt_inc;
		logic     cnt_dec;
		logic     set_ok;
		logic     set_found;
		logic     set_value;
		logic     out_load;   // move result to output register
	} bate_cmd_t;

	typedef struct packed {
		action_t  action;
		logic     full;
		logic     empty;
		logic     idx_le_cnt;
		logic     idx_lt_cnt;
		logic     j_gt_lo;    // j > lower bound of the walk
		logic     j_lt_hi;    // j + 1 < count, never set for find
		logic     i_lt_cnt;
		logic     match;      // read data equals key
		logic     held_lt;    // held value below read data
		logic     out_busy;
	} bate_sts_t;

endpackage

[rtl/core/bate_if.sv]
// ----------------------------------------------------------------------------
// bate_req_if / bate_rsp_if: valid-ready channels of the table engine
// One beat carries a request or a result.
// ----------------------------------------------------------------------------
interface bate_req_if;
	logic                         valid;
	logic                         ready;
	logic [bate_pkg::ACTION_W-1:0] action;
	logic [bate_pkg::KEY_W-1:0]    key;
	logic [bate_pkg::INDEX_W-1:0]  index;
	modport source (output valid, action, key, index, input ready);
	modport sink (input valid, action, key, index, output ready);
endinterface

interface bate_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [bate_pkg::KEY_W-1:0]    value;
	logic                         found;
	logic [bate_pkg::POS_W-1:0]    position;
	logic [bate_pkg::FILL_W-1:0]   fill_count;
	modport source (output valid, ok, value, found, position, fill_count, input ready);
	modport sink (input valid, ok, value, found, position, fill_count, output ready);
endinterface

[rtl/core/bounded_array_table_engine_top.sv]
// ----------------------------------------------------------------------------
// bounded_array_table_engine_top: bounded ordered table with insertion sort
//
//   channel | dir | beat
//   req     | in  | action, key, index
//   rsp     | out | ok, value, found, position, fill_count
//
// One request at a time, sequenced as a walk over the store entries.
// Reset clears the fill count and control; the store needs no clearing.
// A stalled result holds in the output register; the next request is
// taken as soon as the result has been moved there.
// ----------------------------------------------------------------------------
module bounded_array_table_engine_top #(
	parameter int CAPACITY   = bate_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = bate_pkg::DATA_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bate_req_if.sink   req,
	bate_rsp_if.source rsp
);
	import bate_pkg::*;

	bate_cmd_t cmd;
	bate_sts_t sts;

	bate_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bate_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_action     (req.action),
		.req_key        (req.key),
		.req_index      (req.index),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_ok         (rsp.ok),
		.rsp_value      (rsp.value),
		.rsp_found      (rsp.found),
		.rsp_position   (rsp.position),
		.rsp_fill_count (rsp.fill_count)
	);

endmodule

[rtl/core/bate_ctrl.sv]
// ----------------------------------------------------------------------------
// bate_ctrl: controller of the table engine
// Sequences each request over the store, one step a cycle, waiting in ST_DONE while the output register is busy.
// ----------------------------------------------------------------------------
module bate_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bate_pkg::bate_sts_t sts,
	output bate_pkg::bate_cmd_t cmd
);
	import bate_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DONE;
					unique case (sts.action) inside
						ACT_APPEND, ACT_PREPEND, ACT_INSERT_AT: begin
							if (!sts.full && sts.idx_le_cnt) state_d = ST_SHUP_RD;
						end
						ACT_REMOVE_LAST: begin
							if (!sts.empty) begin
								cmd.cnt_dec = 1'b1;
								cmd.set_ok  = 1'b1;
							end
						end
						ACT_REMOVE_FIRST, ACT_REMOVE_AT: begin
							if (sts.idx_lt_cnt) state_d = ST_SHDN_RD;
						end
						ACT_FIND: begin
							cmd.set_ok = 1'b1;
							state_d    = ST_FIND_RD;
						end
						ACT_READ: begin
							if (sts.idx_lt_cnt) state_d = ST_READ_RD;
						end
						ACT_SORT: begin
							cmd.set_ok = 1'b1;
							state_d    = ST_SORT_LD;
						end
						default: ;
					endcase
				end
			end
			// Shift up: j walks from count down to the insert point.
			ST_SHUP_RD: begin
				if (sts.j_gt_lo) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_adr = ADR_JM1;
					state_d    = ST_SHUP_WR;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_adr  = ADR_J;
					cmd.wr_dat  = WD_KEY;
					cmd.cnt_inc = 1'b1;
					cmd.set_ok  = 1'b1;
					state_d     = ST_DONE;
				end
			end
			ST_SHUP_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_adr = ADR_J;
				cmd.wr_dat = WD_RDATA;
				cmd.j_dec  = 1'b1;
				state_d    = ST_SHUP_RD;
			end
			// Shift down: j walks from the removal point up.
			ST_SHDN_RD: begin
				if (sts.j_lt_hi) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_adr = ADR_JP1;
					state_d    = ST_SHDN_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					cmd.set_ok  = 1'b1;
					state_d     = ST_DONE;
				end
			end
			ST_SHDN_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_adr = ADR_J;
				cmd.wr_dat = WD_RDATA;
				cmd.j_inc  = 1'b1;
				state_d    = ST_SHDN_RD;
			end
			// Find: linear scan from the front.
			ST_FIND_RD: begin
				if (sts.j_lt_hi || sts.i_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_adr = ADR_J;
					state_d    = ST_FIND_CMP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FIND_CMP: begin
				if (sts.match) begin
					cmd.set_found = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.j_inc = 1'b1;
					cmd.i_inc = 1'b1;
					state_d   = ST_FIND_RD;
				end
			end
			ST_READ_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_adr = ADR_J;
				state_d    = ST_READ_WAIT;
			end
			ST_READ_WAIT: begin
				cmd.set_value = 1'b1;
				cmd.set_ok    = 1'b1;
				state_d       = ST_DONE;
			end
			// Insertion sort: i is the outer index, j the hole.
			ST_SORT_LD: begin
				if (sts.i_lt_cnt) begin
					cmd.rd_en    = 1'b1;
					cmd.rd_adr   = ADR_I;
					cmd.j_from_i = 1'b1;
					state_d      = ST_SORT_LDW;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SORT_LDW: begin
				cmd.hold_ld = 1'b1;
				state_d     = ST_SORT_RD;
			end
			ST_SORT_RD: begin
				if (sts.j_gt_lo) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_adr = ADR_JM1;
					state_d    = ST_SORT_CMP;
				end else begin
					state_d = ST_SORT_PUT;
				end
			end
			ST_SORT_CMP: begin
				if (sts.held_lt) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_adr = ADR_J;
					cmd.wr_dat = WD_RDATA;
					cmd.j_dec  = 1'b1;
					state_d    = ST_SORT_RD;
				end else begin
					state_d = ST_SORT_PUT;
				end
			end
			ST_SORT_PUT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_adr = ADR_J;
				cmd.wr_dat = WD_HELD;
				cmd.i_inc  = 1'b1;
				state_d    = ST_SORT_LD;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/core/bate_dp.sv]
// ----------------------------------------------------------------------------
// bate_dp: datapath of the table engine
// Entry store, fill count, walk counters and the result register.
// ----------------------------------------------------------------------------
module bate_dp #(
	parameter int CAPACITY   = bate_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = bate_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bate_pkg::bate_cmd_t             cmd,
	output bate_pkg::bate_sts_t             sts,
	input  logic [bate_pkg::ACTION_W-1:0]   req_action,
	input  logic [bate_pkg::KEY_W-1:0]      req_key,
	input  logic [bate_pkg::INDEX_W-1:0]    req_index,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic                            rsp_ok,
	output logic [bate_pkg::KEY_W-1:0]      rsp_value,
	output logic                            rsp_found,
	output logic [bate_pkg::POS_W-1:0]      rsp_position,
	output logic [bate_pkg::FILL_W-1:0]     rsp_fill_count
);
	import bate_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > INDEX_W) ? CW : INDEX_W;

	logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [DATA_WIDTH-1:0] held_q;
	logic [CW-1:0]         cnt_q;
	logic [WW-1:0]         j_q, lo_q, i_q;
	action_t               act_q;
	logic                  ok_q, found_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [WW-1:0]         pos_q;
	logic                  out_v_q;
	logic                  out_ok_q, out_found_q;
	logic [KEY_W-1:0]      out_value_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [FILL_W-1:0]     out_fill_q;
	logic [WW-1:0]         cnt_w, idx_w, j_start, lo_start, rd_a, wr_a;
	logic [DATA_WIDTH-1:0] wd;
	action_t               act_in;

	assign act_in = action_t'(req_action);
	assign cnt_w  = WW'(cnt_q);
	assign idx_w  = WW'(req_index);

	// Walk start and bound per action.
	always_comb begin
		j_start  = '0;
		lo_start = '0;
		case (act_in) inside
			ACT_APPEND:                  begin j_start = cnt_w; lo_start = cnt_w; end
			ACT_PREPEND:                 begin j_start = cnt_w; lo_start = '0;    end
			ACT_INSERT_AT:               begin j_start = cnt_w; lo_start = idx_w; end
			ACT_REMOVE_AT, ACT_READ:     begin j_start = idx_w; end
			ACT_SORT:                    begin j_start = '0; end
			default:                     begin j_start = '0; end
		endcase
	end

	// Status towards the controller.
	always_comb begin
		sts            = '0;
		sts.action     = act_in;
		sts.full       = (cnt_q == CW'(CAPACITY));
		sts.empty      = (cnt_q == '0);
		sts.idx_le_cnt = (act_in != ACT_INSERT_AT) || (idx_w <= cnt_w);
		sts.idx_lt_cnt = (act_in == ACT_REMOVE_FIRST) ? (cnt_q != '0) : (idx_w < cnt_w);
		sts.j_gt_lo    = (j_q > lo_q);
		sts.j_lt_hi    = (act_q != ACT_FIND) && ((j_q + WW'(1)) < cnt_w);
		sts.i_lt_cnt   = (i_q < cnt_w);
		sts.match      = (rdata_q == key_q);
		sts.held_lt    = (held_q < rdata_q);
		sts.out_busy   = out_v_q && !rsp_ready;
	end

	// Store addresses and write data.
	function automatic logic [WW-1:0] pick(adr_sel_t s, logic [WW-1:0] i, logic [WW-1:0] j);
		logic [WW-1:0] r;
		case (s)
			ADR_I:   r = i;
			ADR_J:   r = j;
			ADR_JM1: r = j - WW'(1);
			default: r = j + WW'(1);
		endcase
		return r;
	endfunction

	assign rd_a = pick(cmd.rd_adr, i_q, j_q);
	assign wr_a = pick(cmd.wr_adr, i_q, j_q);

	always_comb begin
		case (cmd.wr_dat)
			WD_KEY:   wd = key_q;
			WD_RDATA: wd = rdata_q;
			default:  wd = held_q;
		endcase
	end

	// Entry store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem_q[wr_a[AW-1:0]] <= wd;
		if (cmd.rd_en) rdata_q <= mem_q[rd_a[AW-1:0]];
	end

	// Request payload, walk counters and working result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= act_in;
			key_q   <= req_key[DATA_WIDTH-1:0];
			j_q     <= j_start;
			lo_q    <= lo_start;
			i_q     <= (act_in == ACT_SORT) ? WW'(1) : '0;
			value_q <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.j_from_i) j_q <= i_q;
			else if (cmd.j_dec) j_q <= j_q - WW'(1);
			else if (cmd.j_inc) j_q <= j_q + WW'(1);
			if (cmd.i_inc) i_q <= i_q + WW'(1);
			if (cmd.j_from_i) lo_q <= '0;
			if (cmd.set_value) value_q <= rdata_q;
			if (cmd.set_found) pos_q <= j_q;
		end
		if (cmd.hold_ld) held_q <= rdata_q;
	end

	// Find walks while i below count: reuse i as scan bound.
	// Control flags and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ok_q    <= 1'b0;
			found_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ok_q    <= cmd.set_ok;
				found_q <= cmd.set_found;
			end else begin
				if (cmd.set_ok) ok_q <= 1'b1;
				if (cmd.set_found) found_q <= 1'b1;
			end
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			else if (cmd.cnt_dec) cnt_q <= cnt_q - CW'(1);
			if (cmd.out_load) out_v_q <= 1'b1;
			else if (rsp_ready) out_v_q <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ok_q    <= ok_q;
			out_value_q <= KEY_W'(value_q);
			out_found_q <= found_q;
			out_pos_q   <= POS_W'(pos_q);
			out_fill_q  <= FILL_W'(cnt_q);
		end
	end

	assign rsp_valid      = out_v_q;
	assign rsp_ok         = out_ok_q;
	assign rsp_value      = out_value_q;
	assign rsp_found      = out_found_q;
	assign rsp_position   = out_pos_q;
	assign rsp_fill_count = out_fill_q;

endmodule

[rtl/core/bate_chk.sv]
// ----------------------------------------------------------------------------
// bate_chk: port checker of the table engine
// Watches the channels for ordering and fill count behaviour.
// ----------------------------------------------------------------------------
module bate_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           rsp_ok,
	input logic                           rsp_found,
	input logic [bate_pkg::POS_W-1:0]     rsp_position,
	input logic [bate_pkg::FILL_W-1:0]    rsp_fill_count
);
	import bate_pkg::*;

	// A result waiting to be taken keeps its beat.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fill_count))
		else $error("stalled result changed");

	// The engine takes no request in the cycle after accepting one.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// A found result always reports success.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_ok)
		else $error("found without ok");

	// Position is zero unless found.
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_position == '0)
		else $error("position without found");

endmodule

bind bounded_array_table_engine_top bate_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.ok),
	.rsp_found      (rsp.found),
	.rsp_position   (rsp.position),
	.rsp_fill_count (rsp.fill_count)
);
